// ===== rtl/rexh_pkg.sv =====
// ----------------------------------------------------------------------------
// rexh_pkg
// Shared types and constants for the random excursion state histogram
// ----------------------------------------------------------------------------
package rexh_pkg;

    localparam int N_STATES    = 8;
    localparam int N_BUCKETS   = 6;
    localparam int STATE_SPAN  = 4;
    localparam int VISIT_W     = 3;
    localparam int STATE_IDX_W = 3;
    localparam int CNT_W       = 17;
    localparam int LIMIT_W     = 16;
    localparam int WALK_W      = 22;
    localparam int WALK_HW_CAP = 2097151;

    localparam logic [VISIT_W-1:0]     VISIT_CAP          = 3'd5;
    localparam logic [CNT_W-1:0]       COUNT_MAX          = 17'h1FFFF;
    localparam logic [LIMIT_W-1:0]     CYCLE_LIMIT_RESET  = 16'd1000;
    localparam logic [STATE_IDX_W-1:0] LAST_STATE         = 3'd7;

    typedef logic [VISIT_W-1:0]     visit_t;
    typedef logic [CNT_W-1:0]       count_t;
    typedef count_t [N_BUCKETS-1:0] bucket_row_t;
    typedef bucket_row_t [N_STATES-1:0] hist_t;

    // input transaction
    typedef struct packed {
        logic bit_value;
        logic end_of_sequence;
    } rexh_in_t;

    // result transaction
    typedef struct packed {
        logic [STATE_IDX_W-1:0] state_index;
        logic [CNT_W-1:0]       visits_zero;
        logic [CNT_W-1:0]       visits_one;
        logic [CNT_W-1:0]       visits_two;
        logic [CNT_W-1:0]       visits_three;
        logic [CNT_W-1:0]       visits_four;
        logic [CNT_W-1:0]       visits_five_plus;
        logic [CNT_W-1:0]       excursion_total;
        logic                   limit_exceeded;
        logic                   last_result;
    } rexh_out_t;

    // walk step outcome handed to the histogram bank
    typedef struct packed {
        logic                      close;
        logic                      zero_close;
        logic                      last;
        visit_t [N_STATES-1:0]     visits;
    } rexh_step_t;

    // end of sequence summary handed to the emitter
    typedef struct packed {
        hist_t  hist;
        count_t total;
        logic   overflow;
    } rexh_summary_t;

endpackage

// ===== rtl/random_excursion_state_histogram.sv =====
// Datapath: bits pass the input register into walk and histogram registers;
// the eight results leave through the snapshot buffer and the output register.
// Throughput: one bit per cycle; results play out one per cycle while m_ready
// is high, so an end bit waits only if the previous eight are still being sent.
// Reset (aresetn low, synchronous): walk, histogram and flags clear, cycle_limit
// returns to 1000.
// ----------------------------------------------------------------------------
// random_excursion_state_histogram
// Random excursion counting stage: walk, per-state visit histogram, results
// ----------------------------------------------------------------------------
module random_excursion_state_histogram #(
    parameter int MAX_SEQUENCE_BITS = 1048576
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  rexh_pkg::rexh_in_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output rexh_pkg::rexh_out_t           m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rexh_pkg::LIMIT_W-1:0]  cfg_wdata
);
    import rexh_pkg::*;

    rexh_in_t            in_reg;
    logic                in_valid_reg;
    logic                advance;
    logic                load;
    logic                emit_busy;
    logic [LIMIT_W-1:0]  cycle_limit_reg;
    rexh_step_t          step;
    rexh_summary_t       summary;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cycle_limit_reg <= CYCLE_LIMIT_RESET;
        end else if (cfg_valid) begin
            cycle_limit_reg <= cfg_wdata;
        end
    end

    // input register; an end bit waits for the snapshot buffer
    assign advance = in_valid_reg && (!in_reg.end_of_sequence || !emit_busy);
    assign load    = advance && in_reg.end_of_sequence;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    rexh_walk #(
        .MAX_SEQUENCE_BITS (MAX_SEQUENCE_BITS)
    ) u_walk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_reg),
        .step    (step)
    );

    rexh_hist u_hist (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .step        (step),
        .cycle_limit (cycle_limit_reg),
        .summary     (summary)
    );

    rexh_emit u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .summary (summary),
        .busy    (emit_busy),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== rtl/rexh_walk.sv =====
// ----------------------------------------------------------------------------
// rexh_walk
// Walk sum and per-excursion state visit counters
// ----------------------------------------------------------------------------
module rexh_walk #(
    parameter int MAX_SEQUENCE_BITS = 1048576
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  rexh_pkg::rexh_in_t   item,
    output rexh_pkg::rexh_step_t step
);
    import rexh_pkg::*;

    localparam int WALK_CAP_INT =
        (MAX_SEQUENCE_BITS < WALK_HW_CAP) ? MAX_SEQUENCE_BITS : WALK_HW_CAP;
    localparam logic signed [WALK_W-1:0] WALK_HI = WALK_W'(WALK_CAP_INT);
    localparam logic signed [WALK_W-1:0] WALK_LO = -WALK_HI;
    localparam logic signed [WALK_W-1:0] SPAN_HI = WALK_W'(STATE_SPAN);
    localparam logic signed [WALK_W-1:0] SPAN_LO = -SPAN_HI;

    logic signed [WALK_W-1:0] walk_reg;
    logic signed [WALK_W-1:0] walk_next;
    visit_t [N_STATES-1:0]    visits_reg;
    visit_t [N_STATES-1:0]    visits_inc;
    logic                     in_range;
    logic                     at_zero;
    logic [STATE_IDX_W-1:0]   state_sel;

    // saturating walk step
    always_comb begin
        walk_next = walk_reg;
        if (item.bit_value) begin
            if (walk_reg < WALK_HI) begin
                walk_next = walk_reg + WALK_W'(1);
            end
        end else begin
            if (walk_reg > WALK_LO) begin
                walk_next = walk_reg - WALK_W'(1);
            end
        end
    end

    // map -4..-1 to 0..3 and 1..4 to 4..7
    assign at_zero   = (walk_next == '0);
    assign in_range  = (walk_next >= SPAN_LO) && (walk_next <= SPAN_HI) && !at_zero;
    assign state_sel = walk_next[STATE_IDX_W-1:0] +
                       (walk_next[WALK_W-1] ? STATE_IDX_W'(4) : STATE_IDX_W'(3));

    // bump the visited state, saturating at the cap
    always_comb begin
        for (int s = 0; s < N_STATES; s++) begin
            visits_inc[s] = visits_reg[s];
            if (in_range && (state_sel == STATE_IDX_W'(s)) && (visits_reg[s] != VISIT_CAP)) begin
                visits_inc[s] = visits_reg[s] + VISIT_W'(1);
            end
        end
    end

    // an excursion closes on a return to zero or at the end of the sequence
    always_comb begin
        step.close      = at_zero || item.end_of_sequence;
        step.zero_close = at_zero;
        step.last       = item.end_of_sequence;
        step.visits     = visits_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_reg   <= '0;
            visits_reg <= '0;
        end else if (step_en) begin
            walk_reg   <= item.end_of_sequence ? '0 : walk_next;
            visits_reg <= (at_zero || item.end_of_sequence) ? '0 : visits_inc;
        end
    end

endmodule

// ===== rtl/rexh_hist.sv =====
// ----------------------------------------------------------------------------
// rexh_hist
// Visit histogram, excursion counter and overflow flag
// ----------------------------------------------------------------------------
module rexh_hist (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           step_en,
    input  rexh_pkg::rexh_step_t           step,
    input  logic [rexh_pkg::LIMIT_W-1:0]   cycle_limit,
    output rexh_pkg::rexh_summary_t        summary
);
    import rexh_pkg::*;

    hist_t  hist_reg;
    hist_t  hist_next;
    count_t count_reg;
    count_t count_next;
    logic   flag_reg;
    logic   flag_next;

    // one saturating bump per state lane, in the bucket of its visit count
    always_comb begin
        for (int s = 0; s < N_STATES; s++) begin
            for (int b = 0; b < N_BUCKETS; b++) begin
                hist_next[s][b] = hist_reg[s][b];
                if (step.close && (step.visits[s] == VISIT_W'(b)) &&
                    (hist_reg[s][b] != COUNT_MAX)) begin
                    hist_next[s][b] = hist_reg[s][b] + CNT_W'(1);
                end
            end
        end
    end

    // excursion count on every close, limit check on returns to zero
    always_comb begin
        count_next = count_reg;
        if (step.close && (count_reg != COUNT_MAX)) begin
            count_next = count_reg + CNT_W'(1);
        end
        flag_next = flag_reg ||
                    (step.zero_close && (count_next > CNT_W'(cycle_limit)));
    end

    always_comb begin
        summary.hist     = hist_next;
        summary.total    = count_next;
        summary.overflow = flag_next;
    end

    // everything clears once the sequence has been handed over
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg  <= '0;
            count_reg <= '0;
            flag_reg  <= 1'b0;
        end else if (step_en) begin
            if (step.last) begin
                hist_reg  <= '0;
                count_reg <= '0;
                flag_reg  <= 1'b0;
            end else begin
                hist_reg  <= hist_next;
                count_reg <= count_next;
                flag_reg  <= flag_next;
            end
        end
    end

endmodule

// ===== rtl/rexh_emit.sv =====
// ----------------------------------------------------------------------------
// rexh_emit
// Snapshot buffer and output register that play out eight results
// ----------------------------------------------------------------------------
module rexh_emit (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  rexh_pkg::rexh_summary_t summary,
    output logic                    busy,
    output logic                    m_valid,
    input  logic                    m_ready,
    output rexh_pkg::rexh_out_t     m_data
);
    import rexh_pkg::*;

    rexh_summary_t          buf_reg;
    logic                   busy_reg;
    logic [STATE_IDX_W-1:0] idx_reg;
    logic                   m_valid_reg;
    rexh_out_t              m_data_reg;
    rexh_out_t              entry;
    logic                   out_free;

    assign out_free = !m_valid_reg || m_ready;

    // result for the current state lane
    always_comb begin
        entry.state_index      = idx_reg;
        entry.visits_zero      = buf_reg.hist[idx_reg][0];
        entry.visits_one       = buf_reg.hist[idx_reg][1];
        entry.visits_two       = buf_reg.hist[idx_reg][2];
        entry.visits_three     = buf_reg.hist[idx_reg][3];
        entry.visits_four      = buf_reg.hist[idx_reg][4];
        entry.visits_five_plus = buf_reg.hist[idx_reg][5];
        entry.excursion_total  = buf_reg.total;
        entry.limit_exceeded   = buf_reg.overflow;
        entry.last_result      = (idx_reg == LAST_STATE);
    end

    // snapshot capture and lane sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (busy_reg && out_free) begin
            idx_reg <= idx_reg + STATE_IDX_W'(1);
            if (idx_reg == LAST_STATE) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            buf_reg <= summary;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_data_reg <= entry;
        end
    end

    assign busy    = busy_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
